// File: hdl/falbc_pkg.sv
`default_nettype none

package falbc_pkg;

   // Largest number of slots by default, and the slot count after reset.
   localparam int MAX_SLOTS_DEFAULT = 64;
   localparam int RESET_ENTRIES     = 64;

   // Field widths of the transactions.
   localparam int OP_W     = 2;
   localparam int DISK_W   = 4;
   localparam int BLOCK_W  = 8;
   localparam int STAMP_W  = 32;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 6;
   localparam int TOTAL_W  = 32;
   localparam int CFG_W    = 7;

   // Operation codes.
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_LOOKUP = 2'd0;
   localparam op_type OP_INSERT = 2'd1;
   localparam op_type OP_UPDATE = 2'd2;

   // Result status codes.
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK       = 3'd0;
   localparam status_type STATUS_MISS     = 3'd1;
   localparam status_type STATUS_EMPTY    = 3'd2;
   localparam status_type STATUS_PRESENT  = 3'd3;
   localparam status_type STATUS_NO_MATCH = 3'd4;

   // One slot of the tag memory.
   typedef struct packed {
      logic               valid;
      logic [DISK_W-1:0]  disk;
      logic [BLOCK_W-1:0] block;
      logic [STAMP_W-1:0] stamp;
   } slot_word_type;

   // Summary flags of one scan over the slots.
   typedef struct packed {
      logic key_hit;
      logic free_found;
      logic slot0_valid;
   } scan_flags_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: hdl/falbc_if.sv
`default_nettype none

// Request channel: one cache operation per transaction.
interface falbc_req_if;
   import falbc_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [DISK_W-1:0]   disk_id;
   logic [BLOCK_W-1:0]  block_id;

   modport source (output valid, output op, output disk_id, output block_id, input ready);
   modport sink   (input valid, input op, input disk_id, input block_id, output ready);
endinterface

// Response channel: one result per request transaction.
interface falbc_rsp_if;
   import falbc_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  slot_index;
   logic [TOTAL_W-1:0]  hit_total;
   logic [TOTAL_W-1:0]  query_total;

   modport source (output valid, output status, output slot_index, output hit_total,
                   output query_total, input ready);
   modport sink   (input valid, input status, input slot_index, input hit_total,
                   input query_total, output ready);
endinterface

// Configuration write channel for the slot count register.
interface falbc_csr_if;
   import falbc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/falbc_ram.sv
`default_nettype none

// Simple dual port RAM with one write port and a registered read port.
module falbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/falbc_scan.sv
`default_nettype none

// Watches the slot words as they stream out of the tag memory and keeps
// the lowest matching slot, the lowest free slot and the oldest slot.
module falbc_scan #(
   parameter int MAX_SLOTS = falbc_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic                                   data_valid,
   input  wire logic [$clog2(MAX_SLOTS)-1:0]           data_slot,
   input  wire falbc_pkg::slot_word_type               data_word,
   input  wire logic [falbc_pkg::DISK_W-1:0]           key_disk,
   input  wire logic [falbc_pkg::BLOCK_W-1:0]          key_block,
   output falbc_pkg::scan_flags_type                   flags,
   output logic      [$clog2(MAX_SLOTS)-1:0]           hit_slot,
   output logic      [$clog2(MAX_SLOTS)-1:0]           free_slot,
   output logic      [$clog2(MAX_SLOTS)-1:0]           min_slot
);
   import falbc_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);

   logic               key_hit_ff, key_hit_in;
   logic               free_ff, free_in;
   logic               slot0_valid_ff, slot0_valid_in;
   logic [SLOT_W-1:0]  hit_slot_ff, hit_slot_in;
   logic [SLOT_W-1:0]  free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]  min_slot_ff, min_slot_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic               first_slot;
   logic               tag_match;

   assign first_slot = (data_slot == '0);
   assign tag_match  = data_word.valid && (data_word.disk == key_disk) &&
                       (data_word.block == key_block);

   // Track the search results one slot per cycle, while data_valid is high.
   always_comb begin
      key_hit_in     = key_hit_ff;
      free_in        = free_ff;
      slot0_valid_in = slot0_valid_ff;
      hit_slot_in    = hit_slot_ff;
      free_slot_in   = free_slot_ff;
      min_slot_in    = min_slot_ff;
      min_stamp_in   = min_stamp_ff;
      if (start) begin
         key_hit_in = 1'b0;
         free_in    = 1'b0;
      end else if (data_valid) begin
         if (!key_hit_ff && tag_match) begin
            key_hit_in  = 1'b1;
            hit_slot_in = data_slot;
         end
         if (!free_ff && !data_word.valid) begin
            free_in      = 1'b1;
            free_slot_in = data_slot;
         end
         // Strict compare keeps the lowest slot on equal stamps.
         if (first_slot) begin
            slot0_valid_in = data_word.valid;
            min_slot_in    = data_slot;
            min_stamp_in   = data_word.stamp;
         end else if (data_word.stamp < min_stamp_ff) begin
            min_slot_in  = data_slot;
            min_stamp_in = data_word.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hit_ff     <= 1'b0;
         free_ff        <= 1'b0;
         slot0_valid_ff <= 1'b0;
      end else begin
         key_hit_ff     <= key_hit_in;
         free_ff        <= free_in;
         slot0_valid_ff <= slot0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      min_slot_ff  <= min_slot_in;
      min_stamp_ff <= min_stamp_in;
   end

   assign flags.key_hit     = key_hit_ff;
   assign flags.free_found  = free_ff;
   assign flags.slot0_valid = slot0_valid_ff;
   assign hit_slot          = hit_slot_ff;
   assign free_slot         = free_slot_ff;
   assign min_slot          = min_slot_ff;

endmodule

`default_nettype wire

// File: hdl/fully_assoc_lru_block_cache.sv
`default_nettype none

// Tag and LRU replacement engine for a fully associative disk-block cache.
// Each request transaction is a lookup, insert or update keyed by disk and
// block number, and returns exactly one response transaction carrying a
// status, the slot number (block data lives in an external memory addressed
// by that slot) and the running hit and lookup counts. Valid marks, tags and
// use stamps sit in one tag memory with a registered read port; every
// request reads all slots up to the slot count, one per cycle, and no new
// request is accepted until its result is decided. The response sits in an
// output register, so a new request is taken while the previous response
// still waits. After reset, and after every write of the slot count
// register, a clearing pass over all MAX_SLOTS slots resets the valid marks;
// no request is accepted during it. Writes of the slot count are clamped to
// 2..MAX_SLOTS and must only be made while the block is idle.
module fully_assoc_lru_block_cache #(
   parameter int MAX_SLOTS = falbc_pkg::MAX_SLOTS_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   falbc_req_if.sink   req_port,
   falbc_rsp_if.source rsp_port,
   falbc_csr_if.sink   csr_port
);
   import falbc_pkg::*;

   localparam int SLOT_W  = $clog2(MAX_SLOTS);
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int WORD_W  = $bits(slot_word_type);
   localparam int START_N = (RESET_ENTRIES < MAX_SLOTS) ? RESET_ENTRIES : MAX_SLOTS;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   entries_ff, entries_in;
   logic [SLOT_W-1:0]  addr_ff, addr_in;
   logic               data_valid_ff;
   logic [SLOT_W-1:0]  data_slot_ff;
   op_type             op_ff;
   logic [DISK_W-1:0]  disk_ff;
   logic [BLOCK_W-1:0] block_ff;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [TOTAL_W-1:0] hits_ff, hits_in;
   logic [TOTAL_W-1:0] queries_ff, queries_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;

   logic                csr_write;
   logic                req_take;
   logic                out_free;
   logic [31:0]         cfg_wide;
   logic [31:0]         cfg_clamped;
   logic [STAMP_W-1:0]  stamp_next;

   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   slot_word_type       wr_word;
   logic                rd_en;
   slot_word_type       rd_word;
   logic [WORD_W-1:0]   rd_bits;

   scan_flags_type      flags;
   logic [SLOT_W-1:0]   hit_slot;
   logic [SLOT_W-1:0]   free_slot;
   logic [SLOT_W-1:0]   min_slot;
   logic [SLOT_W-1:0]   result_slot;
   logic [SLOT_W+INDEX_W-1:0] slot_ext;

   // Handshakes.
   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid;
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   // Clamp the written slot count into the supported range.
   always_comb begin
      cfg_wide = 32'(csr_port.data);
      if (cfg_wide < 32'd2) begin
         cfg_clamped = 32'd2;
      end else if (cfg_wide > 32'(MAX_SLOTS)) begin
         cfg_clamped = 32'(MAX_SLOTS);
      end else begin
         cfg_clamped = cfg_wide;
      end
   end

   // Saturating stamp clock.
   assign stamp_next = (stamp_ff == '1) ? stamp_ff : stamp_ff + 1'b1;

   // Tag memory.
   assign rd_word = slot_word_type'(rd_bits);

   falbc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (WORD_W'(wr_word)),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_bits)
   );

   // Search over the streamed slot words.
   falbc_scan #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take),
      .data_valid (data_valid_ff),
      .data_slot  (data_slot_ff),
      .data_word  (rd_word),
      .key_disk   (disk_ff),
      .key_block  (block_ff),
      .flags      (flags),
      .hit_slot   (hit_slot),
      .free_slot  (free_slot),
      .min_slot   (min_slot)
   );

   // Sequencer: clearing pass, slot scan and the final decision.
   always_comb begin
      state_in      = state_ff;
      entries_in    = entries_ff;
      addr_in       = addr_ff;
      stamp_in      = stamp_ff;
      hits_in       = hits_ff;
      queries_in    = queries_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_word       = '0;
      result_slot   = '0;
      slot_ext      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            addr_in = '0;
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (CNT_W'(addr_ff) == entries_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            wr_word.valid = 1'b1;
            wr_word.disk  = disk_ff;
            wr_word.block = block_ff;
            wr_word.stamp = stamp_next;
            rsp_status_in = STATUS_NO_MATCH;
            unique case (op_ff)
               OP_LOOKUP: begin
                  if (!flags.slot0_valid) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     queries_in = queries_ff + 1'b1;
                     if (flags.key_hit) begin
                        hits_in       = hits_ff + 1'b1;
                        wr_en         = 1'b1;
                        result_slot   = hit_slot;
                        rsp_status_in = STATUS_OK;
                     end else begin
                        rsp_status_in = STATUS_MISS;
                     end
                  end
               end
               OP_INSERT: begin
                  wr_en = 1'b1;
                  if (flags.key_hit) begin
                     result_slot   = hit_slot;
                     rsp_status_in = STATUS_PRESENT;
                  end else begin
                     result_slot   = flags.free_found ? free_slot : min_slot;
                     rsp_status_in = STATUS_OK;
                  end
               end
               OP_UPDATE: begin
                  if (flags.key_hit) begin
                     wr_en         = 1'b1;
                     result_slot   = hit_slot;
                     rsp_status_in = STATUS_OK;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_NO_MATCH;
               end
            endcase
            wr_addr = result_slot;
            if (wr_en) begin
               stamp_in = stamp_next;
            end
            slot_ext     = {{INDEX_W{1'b0}}, result_slot};
            rsp_index_in = slot_ext[INDEX_W-1:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            // Hold everything until the response register can take the result.
            if (!out_free) begin
               wr_en         = 1'b0;
               stamp_in      = stamp_ff;
               hits_in       = hits_ff;
               queries_in    = queries_ff;
               rsp_status_in = rsp_status_ff;
               rsp_index_in  = rsp_index_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_DONE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // A register write sets the slot count and restarts the clearing pass.
      if (csr_write) begin
         entries_in = CNT_W'(cfg_clamped);
         state_in   = ST_CLEAR;
         addr_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         entries_ff    <= CNT_W'(START_N);
         addr_ff       <= '0;
         data_valid_ff <= 1'b0;
         stamp_ff      <= '0;
         hits_ff       <= '0;
         queries_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entries_ff    <= entries_in;
         addr_ff       <= addr_in;
         data_valid_ff <= rd_en;
         stamp_ff      <= stamp_in;
         hits_ff       <= hits_in;
         queries_ff    <= queries_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Request payload and response payload registers.
   always_ff @(posedge clock) begin
      data_slot_ff  <= addr_ff;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      if (req_take) begin
         op_ff    <= op_type'(req_port.op);
         disk_ff  <= req_port.disk_id;
         block_ff <= req_port.block_id;
      end
   end

   // The totals always show the counters after the latest result.
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.slot_index  = rsp_index_ff;
   assign rsp_port.hit_total   = hits_ff;
   assign rsp_port.query_total = queries_ff;

endmodule

`default_nettype wire
